### rtl/ifc8_pkg.sv
// shared types, constants and functions for the imu frame composer
`default_nettype none
package ifc8_pkg;
   localparam int FRAME_WORDS = 18;
   localparam int WORD_IDX_W = 5;
   localparam int FRAME_BITS = 576;

   // one classified record: frame bytes 0..68 packed, earliest byte lowest
   typedef struct packed {
      logic [551:0] body;
   } rec_type;

   // fold the first nbytes bytes of one 32-bit word (earliest in bits 7:0) into a crc-8, poly 07
   function automatic logic [7:0] crc8_word(input logic [7:0] crc_in,
                                            input logic [31:0] word,
                                            input logic [2:0] nbytes);
      logic [7:0] c;
      c = crc_in;
      for (int i = 0; i < 4; i++) begin
         if (i < int'(nbytes)) begin
            c = c ^ word[8*i +: 8];
            for (int b = 0; b < 8; b++) begin
               c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
            end
         end
      end
      return c;
   endfunction

   // 10 * t in single precision, truncated toward zero, saturated to int16
   function automatic logic [15:0] temp_scale(input logic [31:0] bits);
      logic        s;
      logic [7:0]  e;
      logic [23:0] m;
      logic [27:0] p;
      logic [4:0]  lz;
      logic [27:0] pn;
      logic [23:0] q;
      logic        rb;
      logic        st;
      logic [24:0] qr;
      logic signed [10:0] ex;
      logic [47:0] val;
      logic [15:0] mag;
      logic [15:0] res;
      s = bits[31];
      e = bits[30:23];
      m = (e == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
      p = {4'd0, m} * 28'd10;
      lz = 5'd0;
      for (int i = 27; i >= 0; i--) begin
         if (p[i] && lz == 5'd0) lz = 5'(28 - i);
      end
      // lz now holds position+1 counting from msb; normalize top bit to 27
      pn = (lz == 5'd0) ? 28'd0 : (p << (lz - 5'd1));
      q = pn[27:4];
      rb = pn[3];
      st = |pn[2:0];
      qr = {1'b0, q} + 25'((rb && (st || q[0])) ? 1 : 0);
      ex = 11'sd0;
      if (e == 8'd0) ex = 11'sd1; else ex = $signed({3'd0, e});
      // value = q * 2^(ex - 127 - 23 + 4 - (lz-1))
      ex = ex - 11'sd127 - 11'sd23 + 11'sd4 - $signed({6'd0, lz}) + 11'sd1;
      if (qr[24]) begin
         qr = qr >> 1;
         ex = ex + 11'sd1;
      end
      val = 48'd0;
      if (ex >= 11'sd16) val = 48'hFFFF_FFFF_FFFF;
      else if (ex >= 11'sd0) val = {24'd0, qr[23:0]} << ex[4:0];
      else if (ex > -11'sd25) val = {24'd0, qr[23:0]} >> (5'(-ex));
      if (val > 48'd32767) mag = 16'h8000; else mag = val[15:0];
      if (e == 8'hFF && bits[22:0] != 23'd0) res = 16'd0;
      else if (!s) res = (mag == 16'h8000) ? 16'h7FFF : mag;
      else res = 16'(-mag);
      return res;
   endfunction
endpackage
`default_nettype wire

### rtl/ifc8_front.sv
// front end: accepts records, converts temperature, numbers frames
`default_nettype none
module ifc8_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [63:0]          req_accel_xy,
   input  wire logic [63:0]          req_accel_z_gyro_x,
   input  wire logic [63:0]          req_gyro_yz,
   input  wire logic [63:0]          req_attitude_one_two,
   input  wire logic [63:0]          req_attitude_zero_quat_zero,
   input  wire logic [63:0]          req_quat_one_two,
   input  wire logic [31:0]          req_quat_three,
   input  wire logic [31:0]          req_temperature_bits,
   input  wire logic [15:0]          req_status_word,
   input  wire logic [63:0]          req_timestamp_ms,
   output logic                      q_valid,
   output ifc8_pkg::rec_type         q_rec,
   input  wire logic                 q_take
);
   logic [7:0] seq_ff, seq_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   ifc8_pkg::rec_type mem_ff [2];
   ifc8_pkg::rec_type rec;
   logic push_ok;

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_rec = mem_ff[rp_ff];

   always_comb begin
      seq_in = seq_ff + 8'd1;
      rec.body = {req_status_word[7:0],
                  ifc8_pkg::temp_scale(req_temperature_bits),
                  req_quat_three, req_quat_one_two, req_attitude_zero_quat_zero,
                  req_attitude_one_two, req_gyro_yz, req_accel_z_gyro_x,
                  req_accel_xy, req_timestamp_ms, seq_in,
                  8'h40, 8'h10, 8'h00, 8'h5A, 8'hA5};
      cnt_in = cnt_ff + 2'(push_ok) - 2'(q_take);
      wp_in = push_ok ? !wp_ff : wp_ff;
      rp_in = q_take ? !rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 8'd0;
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         if (push_ok) seq_ff <= seq_in;
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wp_ff] <= rec;
   end
endmodule
`default_nettype wire

### rtl/ifc8_back.sv
// back end: streams one frame word per beat and folds the crc
`default_nettype none
module ifc8_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire ifc8_pkg::rec_type  q_rec,
   output logic                    q_take,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [31:0]             rsp_frame_word,
   output logic                    rsp_last_word
);
   logic [ifc8_pkg::WORD_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0] crc_ff, crc_in;
   logic [31:0] w;
   logic pop_ok;

   assign rsp_empty = !q_valid;
   assign pop_ok = rsp_pop && q_valid;
   assign rsp_last_word = (idx_ff == 5'(ifc8_pkg::FRAME_WORDS - 1));
   assign q_take = pop_ok && rsp_last_word;

   always_comb begin
      priority if (idx_ff == 5'(ifc8_pkg::FRAME_WORDS - 1)) begin
         w = {8'h0A, 8'h0D, crc_ff, 8'h00};
      end else begin
         w = q_rec.body[{idx_ff, 5'd0} +: 32];
      end
      if (idx_ff == 5'(ifc8_pkg::FRAME_WORDS - 2)) begin
         rsp_frame_word = w;
      end else begin
         rsp_frame_word = w;
      end
      if (idx_ff == 5'(ifc8_pkg::FRAME_WORDS - 1)) begin
         rsp_frame_word = {8'h0A, 8'h0D, ifc8_pkg::crc8_word(crc_ff,
                           {24'd0, q_rec.body[551:544]}, 3'd1), q_rec.body[551:544]};
      end
      crc_in = ifc8_pkg::crc8_word(crc_ff, w, 3'd4);
      idx_in = rsp_last_word ? '0 : idx_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         crc_ff <= 8'd0;
      end else if (pop_ok) begin
         idx_ff <= idx_in;
         crc_ff <= rsp_last_word ? 8'd0 : crc_in;
      end
   end
endmodule
`default_nettype wire

### rtl/imu_frame_composer_crc8_top.sv
// imu frame composer top level: 72-byte crc-8 frame per sensor record
// the first word of a frame shows on the result side from the registered record queue once earlier frames are popped
// 18 words per record, one 32-bit word per pop beat out of the back end
// a two-entry record queue parts front and back, so the next record is taken while words stream
// reset (synchronous, active high) empties the queue and sets the frame sequence to zero
`default_nettype none
module imu_frame_composer_crc8_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [63:0] req_accel_xy,
   input  wire logic [63:0] req_accel_z_gyro_x,
   input  wire logic [63:0] req_gyro_yz,
   input  wire logic [63:0] req_attitude_one_two,
   input  wire logic [63:0] req_attitude_zero_quat_zero,
   input  wire logic [63:0] req_quat_one_two,
   input  wire logic [31:0] req_quat_three,
   input  wire logic [31:0] req_temperature_bits,
   input  wire logic [15:0] req_status_word,
   input  wire logic [63:0] req_timestamp_ms,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_frame_word,
   output logic             rsp_last_word
);
   logic q_valid, q_take;
   ifc8_pkg::rec_type q_rec;

   ifc8_front u_front (
      .clock, .reset, .req_push, .req_full, .req_accel_xy, .req_accel_z_gyro_x,
      .req_gyro_yz, .req_attitude_one_two, .req_attitude_zero_quat_zero,
      .req_quat_one_two, .req_quat_three, .req_temperature_bits, .req_status_word,
      .req_timestamp_ms, .q_valid, .q_rec, .q_take
   );

   ifc8_back u_back (
      .clock, .reset, .q_valid, .q_rec, .q_take, .rsp_empty, .rsp_pop,
      .rsp_frame_word, .rsp_last_word
   );
endmodule
`default_nettype wire
